[sv/r1dp_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the partitioner.
package r1dp_pkg;

    localparam int MAX_PARTS_DEF   = 16;
    localparam int MAX_SLICES_DEF  = 4096;
    localparam int WEIGHT_BITS_DEF = 32;

    localparam int NP_W       = 5;
    localparam int TGT_W      = 48;
    localparam int MINW_W     = 13;
    localparam int TOT_W      = 13;
    localparam int ACC_W      = 48;
    localparam int WEIGHT_W   = 32;
    localparam int PART_OUT_W = 4;
    localparam int COUNT_W    = 13;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_PAD_W  = OUT_DATA_W - PART_OUT_W - COUNT_W - STATUS_W;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_PARTS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SLICES = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TARGET_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FEW_SLICES  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY_PART  = 2'd3;

    localparam logic KIND_SLICE = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    typedef struct packed {
        logic load;
        logic prep;
        logic mult;
        logic div_step;
        logic decide;
        logic cnt_rd;
        logic cnt_wr;
        logic emit_rd;
        logic emit_out;
    } r1dp_cmd_t;

    typedef struct packed {
        logic div_skip;
        logic div_done;
        logic out_free;
        logic is_last;
        logic idx_last;
    } r1dp_sts_t;

endpackage

[sv/r1dp_ctrl.sv]
// Controller state machine that sequences one slice request through the datapath.
module r1dp_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  r1dp_pkg::r1dp_sts_t   sts,
    output r1dp_pkg::r1dp_cmd_t   cmd
);
    import r1dp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_MULT,
        S_DIV,
        S_DECIDE,
        S_CNT_RD,
        S_CNT_WR,
        S_EMIT_RD,
        S_EMIT_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_MULT;
            end
            S_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = sts.div_skip ? S_DECIDE : S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_CNT_RD;
            end
            S_CNT_RD:
            begin
                cmd.cnt_rd = 1'b1;
                state_next = S_CNT_WR;
            end
            S_CNT_WR:
            begin
                if (sts.out_free)
                begin
                    cmd.cnt_wr = 1'b1;
                    state_next = sts.is_last ? S_EMIT_RD : S_IDLE;
                end
            end
            S_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = S_EMIT_OUT;
            end
            S_EMIT_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_out = 1'b1;
                    state_next   = sts.idx_last ? S_IDLE : S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[sv/r1dp_dp.sv]
// Datapath: configuration, run state, quotient unit, per-part count memory and output register.
module r1dp_dp #(
    parameter int MAX_PARTS   = r1dp_pkg::MAX_PARTS_DEF,
    parameter int MAX_SLICES  = r1dp_pkg::MAX_SLICES_DEF,
    parameter int WEIGHT_BITS = r1dp_pkg::WEIGHT_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [r1dp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [r1dp_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [r1dp_pkg::IN_DATA_W-1:0]       in_data,
    input  logic                                 in_last,
    input  r1dp_pkg::r1dp_cmd_t                  cmd,
    output r1dp_pkg::r1dp_sts_t                  sts,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [r1dp_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                 m_tuser,
    output logic                                 m_tlast
);
    import r1dp_pkg::*;

    localparam int PW    = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int NPW   = $clog2(MAX_PARTS + 1);
    localparam int CW    = $clog2(MAX_SLICES + 1);
    localparam int LW    = (CW > TOT_W) ? CW : TOT_W;
    localparam int PRW   = NPW + MINW_W;
    localparam int CMPW  = (PRW > LW) ? PRW : LW;
    localparam int NUM_W = ACC_W + 1;
    localparam int DW    = NUM_W + NPW;
    localparam int KW    = $clog2(NPW + 1);

    localparam logic [WEIGHT_W-1:0] WMASK = (WEIGHT_BITS >= WEIGHT_W) ? {WEIGHT_W{1'b1}} :
        WEIGHT_W'((64'd1 << WEIGHT_BITS) - 64'd1);
    localparam logic [CW-1:0] SAT_CNT = CW'(MAX_SLICES);

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [WEIGHT_W-1:0] b);
        logic [ACC_W:0] s;
        s = {1'b0, a} + (ACC_W + 1)'(b);
        return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
    endfunction

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (v >= SAT_CNT) ? SAT_CNT : v + CW'(1);
    endfunction

    logic [NP_W-1:0]     num_parts_reg;
    logic [TGT_W-1:0]    target_reg;
    logic [MINW_W-1:0]   min_width_reg;
    logic [TOT_W-1:0]    total_reg;

    logic [WEIGHT_W-1:0] w_reg;
    logic                last_reg;

    logic [PW-1:0]       cur_reg;
    logic [CW-1:0]       ps_reg;
    logic [CW-1:0]       si_reg;
    logic [ACC_W-1:0]    pw_reg;
    logic [ACC_W-1:0]    prefix_reg;

    logic [ACC_W-1:0]    after_reg;
    logic [ACC_W-1:0]    pw_sum_reg;
    logic [LW-1:0]       left_sl_reg;
    logic [PW-1:0]       cur_c_reg;
    logic [PW-1:0]       lp_reg;
    logic [CMPW-1:0]     lp_prod_reg;
    logic [CMPW-1:0]     np_prod_reg;
    logic [NUM_W-1:0]    rem_reg;
    logic [NPW:0]        q_reg;
    logic [KW-1:0]       k_reg;

    logic [STATUS_W-1:0] status_reg;
    logic [PW-1:0]       part_reg;
    logic [PW-1:0]       idx_reg;

    logic [CW-1:0]       cnt_mem [MAX_PARTS];
    logic [MAX_PARTS-1:0] cnt_vld_reg;
    logic [CW-1:0]       rd_data_reg;
    logic                rd_hit_reg;

    logic                m_tvalid_reg;
    logic                out_kind_reg;
    logic [PART_OUT_W-1:0] out_part_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_last_reg;

    logic [NPW-1:0]      np;
    logic [PW-1:0]       np_m1;
    logic [PW-1:0]       cur_clamp;
    logic [PW+MINW_W-1:0] lp_prod_c;
    logic [PRW-1:0]      np_prod_c;
    logic [DW-1:0]       shifted;
    logic                div_ge;
    logic [STATUS_W-1:0] run_status;
    logic [PW-1:0]       mid_part;
    logic                adv;
    logic [PW-1:0]       cur_next;
    logic [PW-1:0]       addr;
    logic [CW-1:0]       cnt_eff;
    logic [STATUS_W-1:0] emit_status;
    logic                out_free;

    always_comb
    begin
        if (num_parts_reg == '0)
        begin
            np = NPW'(1);
        end
        else if (32'(num_parts_reg) > MAX_PARTS)
        begin
            np = NPW'(MAX_PARTS);
        end
        else
        begin
            np = NPW'(num_parts_reg);
        end
    end

    assign np_m1     = PW'(np - NPW'(1));
    assign cur_clamp = (NPW'(cur_reg) >= np) ? np_m1 : cur_reg;
    assign lp_prod_c = lp_reg * min_width_reg;
    assign np_prod_c = np * min_width_reg;
    assign shifted   = DW'({target_reg, 1'b0}) << k_reg;
    assign div_ge    = (DW'(rem_reg) >= shifted);

    always_comb
    begin
        if (target_reg == '0)
        begin
            run_status = ST_TARGET_ZERO;
        end
        else if ((min_width_reg != '0) && (np_prod_reg > CMPW'(total_reg)))
        begin
            run_status = ST_FEW_SLICES;
        end
        else
        begin
            run_status = ST_OK;
        end
    end

    always_comb
    begin
        if (target_reg == '0)
        begin
            mid_part = np_m1;
        end
        else if (q_reg >= (NPW + 1)'(np))
        begin
            mid_part = np_m1;
        end
        else
        begin
            mid_part = PW'(q_reg);
        end
    end

    assign adv = ((pw_sum_reg > target_reg) && (LW'(ps_reg) >= LW'(min_width_reg)))
               || (CMPW'(left_sl_reg) <= lp_prod_reg);

    always_comb
    begin
        if (!adv)
        begin
            cur_next = cur_c_reg;
        end
        else if (cur_c_reg == np_m1)
        begin
            cur_next = np_m1;
        end
        else
        begin
            cur_next = cur_c_reg + PW'(1);
        end
    end

    assign addr        = cmd.emit_rd ? idx_reg : part_reg;
    assign cnt_eff     = rd_hit_reg ? rd_data_reg : '0;
    assign emit_status = ((status_reg == ST_OK) && (cnt_eff == '0)) ? ST_EMPTY_PART : status_reg;
    assign out_free    = !m_tvalid_reg || m_tready;

    assign sts.div_skip = (min_width_reg != '0) || (target_reg == '0);
    assign sts.div_done = (k_reg == '0);
    assign sts.out_free = out_free;
    assign sts.is_last  = last_reg;
    assign sts.idx_last = (idx_reg == np_m1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_parts_reg <= NP_W'(1);
            target_reg    <= TGT_W'(1);
            min_width_reg <= '0;
            total_reg     <= TOT_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NUM_PARTS:    num_parts_reg <= cfg_data[NP_W-1:0];
                CFG_TARGET:       target_reg    <= cfg_data[TGT_W-1:0];
                CFG_MIN_WIDTH:    min_width_reg <= cfg_data[MINW_W-1:0];
                CFG_TOTAL_SLICES: total_reg     <= cfg_data[TOT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg      <= '0;
            ps_reg       <= '0;
            si_reg       <= '0;
            pw_reg       <= '0;
            prefix_reg   <= '0;
            idx_reg      <= '0;
            cnt_vld_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.decide)
            begin
                prefix_reg <= after_reg;
                si_reg     <= sat_inc(si_reg);
                if (min_width_reg == '0)
                begin
                    cur_reg <= mid_part;
                end
                else
                begin
                    cur_reg <= cur_next;
                    pw_reg  <= adv ? '0 : pw_sum_reg;
                    ps_reg  <= adv ? CW'(1) : sat_inc(ps_reg);
                end
            end
            if (cmd.cnt_wr)
            begin
                cnt_vld_reg[part_reg] <= 1'b1;
            end
            if (cmd.emit_out)
            begin
                if (sts.idx_last)
                begin
                    cur_reg     <= '0;
                    ps_reg      <= '0;
                    si_reg      <= '0;
                    pw_reg      <= '0;
                    prefix_reg  <= '0;
                    idx_reg     <= '0;
                    cnt_vld_reg <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + PW'(1);
                end
            end
            if (cmd.cnt_wr || cmd.emit_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            w_reg    <= in_data & WMASK;
            last_reg <= in_last;
        end
        if (cmd.prep)
        begin
            after_reg   <= sat_add(prefix_reg, w_reg);
            pw_sum_reg  <= sat_add(pw_reg, w_reg);
            left_sl_reg <= (LW'(total_reg) > LW'(si_reg)) ? LW'(total_reg) - LW'(si_reg) : '0;
            cur_c_reg   <= cur_clamp;
            lp_reg      <= np_m1 - cur_clamp;
        end
        if (cmd.mult)
        begin
            lp_prod_reg <= CMPW'(lp_prod_c);
            np_prod_reg <= CMPW'(np_prod_c);
            rem_reg     <= NUM_W'(prefix_reg) + NUM_W'(after_reg);
            q_reg       <= '0;
            k_reg       <= KW'(NPW);
        end
        if (cmd.div_step)
        begin
            if (div_ge)
            begin
                rem_reg <= rem_reg - shifted[NUM_W-1:0];
            end
            q_reg <= {q_reg[NPW-1:0], div_ge};
            k_reg <= k_reg - KW'(1);
        end
        if (cmd.decide)
        begin
            status_reg <= run_status;
            part_reg   <= (min_width_reg == '0) ? mid_part : cur_next;
        end
        if (cmd.cnt_rd || cmd.emit_rd)
        begin
            rd_data_reg <= cnt_mem[addr];
            rd_hit_reg  <= cnt_vld_reg[addr];
        end
        if (cmd.cnt_wr)
        begin
            cnt_mem[part_reg] <= sat_inc(cnt_eff);
            out_kind_reg      <= KIND_SLICE;
            out_part_reg      <= PART_OUT_W'(part_reg);
            out_count_reg     <= '0;
            out_status_reg    <= status_reg;
            out_last_reg      <= 1'b0;
        end
        if (cmd.emit_out)
        begin
            out_kind_reg   <= KIND_COUNT;
            out_part_reg   <= PART_OUT_W'(idx_reg);
            out_count_reg  <= COUNT_W'(cnt_eff);
            out_status_reg <= emit_status;
            out_last_reg   <= sts.idx_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_status_reg, out_count_reg, out_part_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

[sv/rectilinear_1d_partitioner_top.sv]
// Top level of the one-dimensional rectilinear partitioner.
// Each slice request gives one assignment result; a slice marked tlast also gives one count
// result per part, part 0 upward, the final one with tlast. Greedy mode (min_width nonzero,
// or target zero) skips the quotient unit; midpoint mode runs the restoring quotient unit,
// which retires one quotient bit per cycle. A last slice adds a count memory read and an
// output load per part. Output stalls hold the result loads. A new request is taken while
// the previous final result still waits in the output register.
module rectilinear_1d_partitioner_top #(
    parameter int MAX_PARTS   = r1dp_pkg::MAX_PARTS_DEF,
    parameter int MAX_SLICES  = r1dp_pkg::MAX_SLICES_DEF,
    parameter int WEIGHT_BITS = r1dp_pkg::WEIGHT_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [r1dp_pkg::IN_DATA_W-1:0]    s_tdata,   // weight[31:0]
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [r1dp_pkg::OUT_DATA_W-1:0]   m_tdata,   // part[3:0], count[16:4], status[18:17]
    output logic                              m_tuser,   // kind[0]
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [r1dp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [r1dp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import r1dp_pkg::*;

    r1dp_cmd_t cmd;
    r1dp_sts_t sts;

    r1dp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    r1dp_dp #(
        .MAX_PARTS   (MAX_PARTS),
        .MAX_SLICES  (MAX_SLICES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .in_last   (s_tlast),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command active");

    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.cnt_wr || cmd.emit_out) |-> sts.out_free)
        else $error("result loaded over a pending result");

    a_last_is_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tuser == KIND_COUNT))
        else $error("final result of a run is not a count result");

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while one is in progress");

endmodule
